// ===== src/sspp_pkg.sv =====
// shared types and constants for the servo status packet parser
package sspp_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] LEN_OVH  = 8'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_MASK  = 1'b1;

    localparam logic [BYTE_W-1:0] UNKNOWN_MASK_RST = 8'd128;

    typedef enum logic [7:0] {
        PH_HUNT = 8'b0000_0001,
        PH_ID   = 8'b0000_0010,
        PH_LEN  = 8'b0000_0100,
        PH_ERR  = 8'b0000_1000,
        PH_DATA = 8'b0001_0000,
        PH_CSUM = 8'b0010_0000,
        PH_SKIP = 8'b0100_0000,
        PH_DONE = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic              is_status;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] status;
    } t_result;

endpackage

// ===== src/sspp_fsm.sv =====
// packet phase tracking, config registers and result generation
module sspp_fsm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sspp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sspp_pkg::BYTE_W-1:0]       i_cfg_data,
    input  logic                              i_fire,
    input  logic                              i_action,
    input  logic [sspp_pkg::BYTE_W-1:0]       i_byte,
    output logic                              o_push,
    output sspp_pkg::t_result                 o_res
);
    import sspp_pkg::*;

    logic [BYTE_W-1:0] r_expected_size;
    logic [BYTE_W-1:0] r_unknown_mask;
    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_prev, n_prev;
    logic [BYTE_W-1:0] r_left, n_left;
    logic [BYTE_W-1:0] r_err, n_err;
    logic              r_mismatch, n_mismatch;
    logic              r_first, n_first;

    logic [BYTE_W:0]   want;
    logic [BYTE_W-1:0] len_trim;
    logic [BYTE_W-1:0] left_dec;

    assign want     = {1'b0, r_expected_size} + {1'b0, LEN_OVH};
    assign len_trim = (r_left < LEN_OVH) ? '0 : r_left - LEN_OVH;
    assign left_dec = r_left - 8'd1;

    always_comb begin
        n_phase    = r_phase;
        n_prev     = r_prev;
        n_left     = r_left;
        n_err      = r_err;
        n_mismatch = r_mismatch;
        n_first    = r_first;
        o_push     = 1'b0;
        o_res      = '0;
        if (i_action) begin
            // window close: unknown status unless one was given
            if (r_phase != PH_DONE) begin
                o_push         = 1'b1;
                o_res.is_status = 1'b1;
                o_res.status   = r_unknown_mask;
            end
            n_phase = PH_HUNT;
            n_first = 1'b0;
        end else begin
            case (r_phase)
                PH_HUNT: begin
                    if (r_first && r_prev == HDR_BYTE && i_byte == HDR_BYTE) begin
                        n_phase = PH_ID;
                    end
                    n_prev  = i_byte;
                    n_first = 1'b1;
                end
                PH_ID: begin
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_left  = i_byte;
                    n_phase = PH_ERR;
                end
                PH_ERR: begin
                    n_err  = i_byte;
                    n_left = len_trim;
                    if (want == {1'b0, r_left}) begin
                        n_mismatch = 1'b0;
                        n_phase    = (len_trim == '0) ? PH_CSUM : PH_DATA;
                    end else begin
                        n_mismatch = 1'b1;
                        if (len_trim == '0) begin
                            o_push          = 1'b1;
                            o_res.is_status = 1'b1;
                            o_res.status    = i_byte & r_unknown_mask;
                            n_phase         = PH_DONE;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_DATA: begin
                    o_push          = 1'b1;
                    o_res.data_byte = i_byte;
                    n_left          = left_dec;
                    if (left_dec == '0) begin
                        n_phase = PH_CSUM;
                    end
                end
                PH_CSUM: begin
                    // checksum is not verified
                    o_push          = 1'b1;
                    o_res.is_status = 1'b1;
                    o_res.status    = r_err;
                    n_phase         = PH_DONE;
                end
                PH_SKIP: begin
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        o_push          = 1'b1;
                        o_res.is_status = 1'b1;
                        o_res.status    = r_err & r_unknown_mask;
                        n_phase         = PH_DONE;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_size <= '0;
            r_unknown_mask  <= UNKNOWN_MASK_RST;
            r_phase         <= PH_HUNT;
            r_prev          <= '0;
            r_left          <= '0;
            r_err           <= '0;
            r_mismatch      <= 1'b0;
            r_first         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_EXPECTED_SIZE: r_expected_size <= i_cfg_data;
                    CFG_UNKNOWN_MASK:  r_unknown_mask  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_fire) begin
                r_phase    <= n_phase;
                r_prev     <= n_prev;
                r_left     <= n_left;
                r_err      <= n_err;
                r_mismatch <= n_mismatch;
                r_first    <= n_first;
            end
        end
    end

    // a status on a byte request always parks the parser until close
    a_status_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_push && o_res.is_status && !i_action) |=> r_phase == PH_DONE)
        else $error("status emitted without entering done phase");

    // data bytes only come out of the payload phase
    a_data_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !o_res.is_status) |-> (r_phase == PH_DATA && !r_mismatch))
        else $error("data result outside payload phase");

endmodule

// ===== src/sspp_out_buf.sv =====
// result register with one skid entry
module sspp_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sspp_pkg::t_result  i_res,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output sspp_pkg::t_result  o_res
);
    import sspp_pkg::*;

    logic    r_main_vld;
    logic    r_skid_vld;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_vld && !i_stall;
    assign o_valid = r_main_vld;
    assign o_res   = r_main;
    assign o_full  = r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (pop) begin
                if (r_skid_vld) begin
                    r_main_vld <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_main_vld <= i_push;
                end
            end else if (i_push) begin
                if (!r_main_vld) begin
                    r_main_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_vld) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_res;
            end
        end else if (i_push) begin
            if (!r_main_vld) begin
                r_main <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end

    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_main_vld)
        else $error("skid entry held with empty output register");

    // a pop with the skid entry full moves it up
    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_stall) |=> (r_main_vld && !r_skid_vld && r_main == $past(r_skid)))
        else $error("skid entry not promoted on pop");

endmodule

// ===== src/servo_status_packet_parser_core.sv =====
// top level of the servo status packet parser
//
//  channel   direction  handshake                    payload
//  in        input      i_in_valid / o_in_stall      i_action, i_rx_byte
//  out       output     o_out_valid / i_out_stall    o_is_status, o_data_byte, o_status
//  cfg       input      i_cfg_we                     i_cfg_idx, i_cfg_data
//
//  one request per clock sustained while the skid entry is not full; a result
//  reaches the outputs through the input register, then the result register
//  the result register plus one skid entry let the input side keep moving
//  while the output side is stalled; input stalls once the skid entry fills
//  synchronous active-low reset clears the phase and handshake state and resets the config (size 0, mask 128)
module servo_status_packet_parser_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sspp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sspp_pkg::BYTE_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_action,
    input  logic [sspp_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_is_status,
    output logic [sspp_pkg::BYTE_W-1:0]    o_data_byte,
    output logic [sspp_pkg::BYTE_W-1:0]    o_status
);
    import sspp_pkg::*;

    logic              r_in_vld;
    logic              r_action;
    logic [BYTE_W-1:0] r_byte;
    logic              fire;
    logic              accept;
    logic              buf_full;
    logic              push;
    t_result           res;
    t_result           out_res;

    assign fire       = r_in_vld && !buf_full;
    assign o_in_stall = r_in_vld && !fire;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_byte   <= i_rx_byte;
        end
    end

    sspp_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_action   (r_action),
        .i_byte     (r_byte),
        .o_push     (push),
        .o_res      (res)
    );

    sspp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && fire),
        .i_res   (res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res)
    );

    assign o_is_status = out_res.is_status;
    assign o_data_byte = out_res.data_byte;
    assign o_status    = out_res.status;

endmodule
